// ===== rtl/core/yfre_pkg.sv =====
// ----------------------------------------------------------------------------
// yfre_pkg: shared types and constants of the file receiver engine
// Protocol codes, command and result records, and the cancel text tables.
// ----------------------------------------------------------------------------
package yfre_pkg;

    typedef enum logic [1:0] {
        PS_WAIT_START,
        PS_WAIT_HEADER,
        PS_DATA,
        PS_CANCEL_WAIT
    } proto_state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_REPLY,
        ACT_STATUS,
        ACT_CANCEL
    } act_t;

    typedef enum logic [1:0] {
        MSG_OPER,
        MSG_RTO,
        MSG_TO,
        MSG_PV
    } msg_t;

    // Input kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // Result destinations
    localparam logic [1:0] DEST_PEER   = 2'd0;
    localparam logic [1:0] DEST_DATA   = 2'd1;
    localparam logic [1:0] DEST_HEADER = 2'd2;
    localparam logic [1:0] DEST_STATUS = 2'd3;

    // Status codes
    localparam logic [3:0] STS_NONE        = 4'd0;
    localparam logic [3:0] STS_SESSION_END = 4'd1;
    localparam logic [3:0] STS_FILE_DONE   = 4'd2;
    localparam logic [3:0] STS_PEER_ABORT  = 4'd3;
    localparam logic [3:0] STS_TIMEOUT     = 4'd4;
    localparam logic [3:0] STS_NOT_READY   = 4'd5;
    localparam logic [3:0] STS_OPER_ABORT  = 4'd6;
    localparam logic [3:0] STS_PROTO_ERR   = 4'd7;
    localparam logic [3:0] STS_HEADER_DONE = 4'd8;

    // Frame type bytes
    localparam logic [7:0] FT_HEADER = 8'h01;
    localparam logic [7:0] FT_DATA   = 8'h02;
    localparam logic [7:0] FT_EOF    = 8'h03;
    localparam logic [7:0] FT_EOT    = 8'h04;
    localparam logic [7:0] FT_ENQ    = 8'h05;
    localparam logic [7:0] FT_ACK    = 8'h06;
    localparam logic [7:0] FT_DLE    = 8'h10;
    localparam logic [7:0] FT_NAK    = 8'h15;
    localparam logic [7:0] FT_CAN    = 8'h18;

    // Second byte of two-byte replies
    localparam logic [7:0] RPL_RR = 8'h01;
    localparam logic [7:0] RPL_RF = 8'h02;
    localparam logic [7:0] RPL_AF = 8'h03;
    localparam logic [7:0] RPL_AT = 8'h04;
    localparam logic [7:0] RPL_CA = 8'h05;

    // Result position counter width: up to 21 results per item
    localparam int RPOS_W = 5;

    localparam logic [8*19-1:0] TXT_OPER = "Aborted by operator";
    localparam logic [8*15-1:0] TXT_RTO  = "Receive timeout";
    localparam logic [8*7-1:0]  TXT_TO   = "Timeout";
    localparam logic [8*18-1:0] TXT_PV   = "Protocol violation";

    localparam logic [RPOS_W-1:0] LEN_OPER = 5'd19;
    localparam logic [RPOS_W-1:0] LEN_RTO  = 5'd15;
    localparam logic [RPOS_W-1:0] LEN_TO   = 5'd7;
    localparam logic [RPOS_W-1:0] LEN_PV   = 5'd18;

    typedef struct packed {
        logic                 stream_en;
        logic [1:0]           stream_dest;
        logic [7:0]           stream_byte;
        act_t                 act;
        logic [7:0]           arg;
        msg_t                 msg;
        logic [3:0]           status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
        logic [3:0] status;
    } result_t;

    function automatic logic [RPOS_W-1:0] msg_len(msg_t m);
        logic [RPOS_W-1:0] n;
        n = LEN_PV;
        case (m)
            MSG_OPER: n = LEN_OPER;
            MSG_RTO:  n = LEN_RTO;
            MSG_TO:   n = LEN_TO;
            MSG_PV:   n = LEN_PV;
            default:  n = LEN_PV;
        endcase
        return n;
    endfunction

    // Character idx of the text, first character at idx 0
    function automatic logic [7:0] msg_char(msg_t m, logic [RPOS_W-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (m)
            MSG_OPER:
                if (idx < LEN_OPER) c = TXT_OPER[8*(int'(LEN_OPER) - 1 - int'(idx)) +: 8];
            MSG_RTO:
                if (idx < LEN_RTO) c = TXT_RTO[8*(int'(LEN_RTO) - 1 - int'(idx)) +: 8];
            MSG_TO:
                if (idx < LEN_TO) c = TXT_TO[8*(int'(LEN_TO) - 1 - int'(idx)) +: 8];
            MSG_PV:
                if (idx < LEN_PV) c = TXT_PV[8*(int'(LEN_PV) - 1 - int'(idx)) +: 8];
            default:
                c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/yfre_front.sv =====
// ----------------------------------------------------------------------------
// yfre_front: frame delimiter and protocol state machine
// Accepts one item a cycle, tracks framing, idle time and protocol state,
// and issues at most one command record describing the results of that item.
// ----------------------------------------------------------------------------
module yfre_front
    import yfre_pkg::*;
#(
    parameter int FRAME_CAP = 300
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    localparam int CNT_W = $clog2(FRAME_CAP);
    localparam int N_W   = CNT_W + 1;

    proto_state_t     state_reg, state_next;
    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic [7:0]       frame_type_reg, frame_type_next;
    logic [7:0]       frame_len_reg, frame_len_next;
    logic [7:0]       enq_len_reg, enq_len_next;
    logic [7:0]       idle_ticks_reg, idle_ticks_next;
    logic [7:0]       timeout_reg;

    logic           is_byte, is_tick, is_abort;
    logic [N_W-1:0] n;
    logic [7:0]     ftype, flen, fenq;
    logic           frame_end;
    logic [N_W-1:0] data_len;
    logic [7:0]     idle_inc, limit;
    logic           tick_fire;
    logic           strm_en;
    logic [1:0]     strm_dest;
    proto_state_t   fr_state;
    act_t           fr_act;
    logic [7:0]     fr_arg;
    logic [3:0]     fr_status;

    // Decode of the current item
    always_comb
    begin
        is_byte  = in_valid && (kind == KIND_BYTE);
        is_tick  = in_valid && (kind == KIND_TICK);
        is_abort = in_valid && (kind == KIND_ABORT);

        n     = N_W'(frame_count_reg) + N_W'(1);
        ftype = (frame_count_reg == '0) ? rx_byte : frame_type_reg;
        if (frame_count_reg == '0)
            flen = 8'h00;
        else if (frame_count_reg == CNT_W'(1))
            flen = rx_byte;
        else
            flen = frame_len_reg;
        if (frame_count_reg == CNT_W'(2))
            fenq = rx_byte;
        else if (frame_count_reg == '0)
            fenq = 8'h00;
        else
            fenq = enq_len_reg;

        data_len = (flen == 8'h00) ? N_W'(256) : N_W'(flen);
        case (ftype)
            FT_ACK, FT_EOF, FT_EOT:
                frame_end = (n >= N_W'(2));
            FT_DATA:
                frame_end = (n >= N_W'(2)) && (n >= data_len + N_W'(2));
            FT_HEADER, FT_NAK, FT_CAN, FT_DLE:
                frame_end = (n >= N_W'(2)) && (n >= N_W'(flen) + N_W'(2));
            FT_ENQ:
                frame_end = ((n >= N_W'(2)) && (flen == 8'h01))
                          || ((n >= N_W'(3)) && (n >= N_W'(fenq) + N_W'(3)));
            default:
                frame_end = 1'b1;
        endcase
        if (n >= N_W'(FRAME_CAP))
            frame_end = 1'b1;

        // Stream payload from the third byte on
        strm_en   = 1'b0;
        strm_dest = DEST_DATA;
        if (frame_count_reg >= CNT_W'(2))
        begin
            if (state_reg == PS_DATA && ftype == FT_DATA)
            begin
                strm_en   = 1'b1;
                strm_dest = DEST_DATA;
            end
            else if (state_reg == PS_WAIT_HEADER && ftype == FT_HEADER && flen != 8'h00)
            begin
                strm_en   = 1'b1;
                strm_dest = DEST_HEADER;
            end
        end

        idle_inc  = (idle_ticks_reg == 8'hFF) ? 8'hFF : idle_ticks_reg + 8'd1;
        limit     = (timeout_reg == 8'h00) ? 8'h01 : timeout_reg;
        tick_fire = idle_inc >= limit;

        // Reaction to a completed frame
        fr_state  = state_reg;
        fr_act    = ACT_NONE;
        fr_arg    = RPL_CA;
        fr_status = STS_NONE;
        if (ftype == FT_CAN)
        begin
            fr_act    = ACT_REPLY;
            fr_arg    = RPL_CA;
            fr_status = STS_PEER_ABORT;
            fr_state  = PS_WAIT_START;
        end
        else
        begin
            case (state_reg)
                PS_WAIT_START:
                    if (ftype == FT_ENQ && flen == 8'h01)
                    begin
                        fr_act   = ACT_REPLY;
                        fr_arg   = RPL_RR;
                        fr_state = PS_WAIT_HEADER;
                    end
                    else if (ftype == FT_NAK)
                    begin
                        fr_act    = ACT_STATUS;
                        fr_status = STS_NOT_READY;
                    end
                PS_WAIT_HEADER:
                    if (ftype == FT_HEADER && flen != 8'h00)
                    begin
                        fr_act    = ACT_REPLY;
                        fr_arg    = RPL_RF;
                        fr_status = STS_HEADER_DONE;
                        fr_state  = PS_DATA;
                    end
                    else if (ftype == FT_ENQ && flen == 8'h01)
                    begin
                        fr_act = ACT_NONE;
                    end
                    else if (ftype == FT_EOT && flen == 8'h01)
                    begin
                        fr_act    = ACT_REPLY;
                        fr_arg    = RPL_AT;
                        fr_status = STS_SESSION_END;
                        fr_state  = PS_WAIT_START;
                    end
                    else
                    begin
                        fr_act    = ACT_CANCEL;
                        fr_status = STS_PROTO_ERR;
                        fr_state  = PS_CANCEL_WAIT;
                    end
                PS_DATA:
                    if (ftype == FT_DATA)
                    begin
                        fr_act = ACT_NONE;
                    end
                    else if (ftype == FT_EOF && flen == 8'h01)
                    begin
                        fr_act    = ACT_REPLY;
                        fr_arg    = RPL_AF;
                        fr_status = STS_FILE_DONE;
                        fr_state  = PS_WAIT_HEADER;
                    end
                    else
                    begin
                        fr_act    = ACT_CANCEL;
                        fr_status = STS_PROTO_ERR;
                        fr_state  = PS_CANCEL_WAIT;
                    end
                default:
                    if (ftype == FT_ACK && flen == 8'h05)
                    begin
                        fr_act    = ACT_STATUS;
                        fr_status = STS_SESSION_END;
                        fr_state  = PS_WAIT_START;
                    end
                    else
                    begin
                        fr_act = ACT_REPLY;
                        fr_arg = RPL_CA;
                    end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next       = state_reg;
        frame_count_next = frame_count_reg;
        frame_type_next  = frame_type_reg;
        frame_len_next   = frame_len_reg;
        enq_len_next     = enq_len_reg;
        idle_ticks_next  = idle_ticks_reg;
        if (is_byte)
        begin
            idle_ticks_next = 8'h00;
            if (frame_end)
            begin
                frame_count_next = '0;
                frame_type_next  = 8'h00;
                frame_len_next   = 8'h00;
                enq_len_next     = 8'h00;
                state_next       = fr_state;
            end
            else
            begin
                frame_count_next = n[CNT_W-1:0];
                frame_type_next  = ftype;
                frame_len_next   = flen;
                enq_len_next     = fenq;
            end
        end
        else if (is_tick)
        begin
            if (tick_fire)
            begin
                frame_count_next = '0;
                frame_type_next  = 8'h00;
                frame_len_next   = 8'h00;
                enq_len_next     = 8'h00;
                idle_ticks_next  = 8'h00;
                state_next = (state_reg == PS_CANCEL_WAIT) ? PS_WAIT_START : PS_CANCEL_WAIT;
            end
            else
            begin
                idle_ticks_next = idle_inc;
            end
        end
        else if (is_abort)
        begin
            frame_count_next = '0;
            frame_type_next  = 8'h00;
            frame_len_next   = 8'h00;
            enq_len_next     = 8'h00;
            idle_ticks_next  = 8'h00;
            state_next       = PS_WAIT_START;
        end
    end

    // Command output
    always_comb
    begin
        cmd             = '0;
        cmd.act         = ACT_NONE;
        cmd.msg         = MSG_PV;
        cmd.stream_dest = strm_dest;
        cmd.stream_byte = rx_byte;
        if (is_byte)
        begin
            cmd.stream_en = strm_en;
            if (frame_end)
            begin
                cmd.act    = fr_act;
                cmd.arg    = fr_arg;
                cmd.status = fr_status;
            end
        end
        else if (is_tick && tick_fire)
        begin
            cmd.status = STS_TIMEOUT;
            case (state_reg)
                PS_WAIT_START, PS_WAIT_HEADER:
                begin
                    cmd.act = ACT_CANCEL;
                    cmd.msg = MSG_RTO;
                end
                PS_DATA:
                begin
                    cmd.act = ACT_CANCEL;
                    cmd.msg = MSG_TO;
                end
                default:
                    cmd.act = ACT_STATUS;
            endcase
        end
        else if (is_abort)
        begin
            cmd.act    = ACT_CANCEL;
            cmd.msg    = MSG_OPER;
            cmd.status = STS_OPER_ABORT;
        end
        cmd_valid = in_valid && (cmd.stream_en || cmd.act != ACT_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= PS_WAIT_START;
            frame_count_reg <= '0;
            frame_type_reg  <= 8'h00;
            frame_len_reg   <= 8'h00;
            enq_len_reg     <= 8'h00;
            idle_ticks_reg  <= 8'h00;
            timeout_reg     <= 8'd120;
        end
        else
        begin
            state_reg       <= state_next;
            frame_count_reg <= frame_count_next;
            frame_type_reg  <= frame_type_next;
            frame_len_reg   <= frame_len_next;
            enq_len_reg     <= enq_len_next;
            idle_ticks_reg  <= idle_ticks_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/core/yfre_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// yfre_cmd_fifo: command queue between front and back
// Small register queue of command records; the head is shown combinationally.
// ----------------------------------------------------------------------------
module yfre_cmd_fifo
    import yfre_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        full     = (count_reg == CNT_W'(DEPTH));
        rd_valid = (count_reg != '0);
        rd_data  = mem_reg[rd_ptr_reg];
        do_wr    = wr_en && !full;
        do_rd    = rd_en && rd_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/yfre_back.sv =====
// ----------------------------------------------------------------------------
// yfre_back: result sequencer
// Expands the head command into result items into the result register that
// the consumer pops, one a cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module yfre_back
    import yfre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       head_pop,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] dest,
    output logic [7:0] out_byte,
    output logic       last,
    output logic [3:0] status
);

    logic [RPOS_W-1:0] pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           item;
    logic [RPOS_W-1:0] act_len, total, k;
    logic              advance;

    always_comb
    begin
        case (head.act)
            ACT_REPLY:  act_len = RPOS_W'(2);
            ACT_STATUS: act_len = RPOS_W'(1);
            ACT_CANCEL: act_len = msg_len(head.msg) + RPOS_W'(2);
            default:    act_len = '0;
        endcase
        total = act_len + RPOS_W'(head.stream_en);
        k     = pos_reg - RPOS_W'(head.stream_en);

        item.dest = DEST_PEER;
        item.data = 8'h00;
        if (head.stream_en && pos_reg == '0)
        begin
            item.dest = head.stream_dest;
            item.data = head.stream_byte;
        end
        else
        begin
            case (head.act)
                ACT_REPLY:
                    item.data = (k == '0) ? FT_ACK : head.arg;
                ACT_STATUS:
                    item.dest = DEST_STATUS;
                ACT_CANCEL:
                    if (k == '0)
                        item.data = FT_CAN;
                    else if (k == RPOS_W'(1))
                        item.data = {{(8 - RPOS_W){1'b0}}, msg_len(head.msg)};
                    else
                        item.data = msg_char(head.msg, k - RPOS_W'(2));
                default:
                    item.data = 8'h00;
            endcase
        end
        item.last   = (pos_reg == total - RPOS_W'(1));
        item.status = item.last ? head.status : STS_NONE;

        advance  = head_valid && (!out_valid_reg || pop);
        head_pop = advance && item.last;
        pos_next = pos_reg;
        if (advance)
            pos_next = item.last ? '0 : pos_reg + RPOS_W'(1);
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign dest     = out_reg.dest;
    assign out_byte = out_reg.data;
    assign last     = out_reg.last;
    assign status   = out_reg.status;

endmodule

// ===== rtl/core/yapp_file_receiver_engine.sv =====
// ----------------------------------------------------------------------------
// yapp_file_receiver_engine: receiver side of a byte-oriented file transfer
// Frames link bytes, runs the receive protocol and emits replies, file data,
// header text and status as a queue of result items.
// ----------------------------------------------------------------------------
// The block takes one item (link byte, one-second tick or operator abort) per
// cycle whenever full is low, and every item is classified in the cycle it is
// accepted. Its results leave through the result queue at one item per cycle
// while pop is held: a streamed payload byte is one result, a reply two, and
// a cancel frame with its reason text up to 21. The front accepts items at one
// per cycle for as long as the command queue (CMD_DEPTH entries) has room, so
// the sustained rate is one item per cycle for data streaming and is set by the
// result sequencer's one-result-per-cycle port during reply bursts. Write
// timeout_seconds through cfg_wr_en/cfg_wr_data only while the block is idle;
// a value of zero acts as one. No clearing pass is needed after reset.
module yapp_file_receiver_engine
    import yfre_pkg::*;
#(
    parameter int FRAME_CAP = 300,
    parameter int CMD_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    // input queue side
    input  logic       push,
    output logic       full,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    // result queue side
    output logic       empty,
    input  logic       pop,
    output logic [1:0] dest,
    output logic [7:0] out_byte,
    output logic       last,
    output logic [3:0] status,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic in_valid;
    logic cmd_valid;
    cmd_t cmd;
    logic head_valid;
    cmd_t head;
    logic head_pop;

    // Accept an item on every transfer; the command queue's room sets full.
    assign in_valid = push && !full;

    // Front: frame delimiting, timeout counting and protocol state.
    yfre_front #(
        .FRAME_CAP (FRAME_CAP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    // Hold commands so the front keeps going while a reply burst drains.
    yfre_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_valid),
        .wr_data  (cmd),
        .full     (full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head)
    );

    // Back: expand each command into result transfers.
    yfre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .dest       (dest),
        .out_byte   (out_byte),
        .last       (last),
        .status     (status)
    );

endmodule

// ===== rtl/core/yfre_checker.sv =====
// ----------------------------------------------------------------------------
// yfre_checker: port-level checks of the file receiver engine
// Watches the result queue for stability and for well-formed result items.
// ----------------------------------------------------------------------------
module yfre_checker
    import yfre_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] dest,
    input logic [7:0] out_byte,
    input logic       last,
    input logic [3:0] status
);

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(dest) && $stable(out_byte)
                              && $stable(last) && $stable(status)))
    else $error("result changed while waiting");

    // Only the final result of an item carries a status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STS_NONE) |-> last)
    else $error("status on a non-final result");

    // A status-only result carries no byte and a real status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dest == DEST_STATUS) |-> (out_byte == 8'h00 && status != STS_NONE))
    else $error("malformed status-only result");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= STS_HEADER_DONE))
    else $error("undefined status code");

endmodule

bind yapp_file_receiver_engine yfre_checker u_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the file receiver engine
// Feeds link bytes, ticks and operator aborts into the engine's input queue,
// predicts every reply, data, header and status result in a scoreboard class,
// and compares what leaves the result queue field by field.
// ----------------------------------------------------------------------------
module tb_top
    import yfre_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         FRAME_LIMIT   = 300;
    localparam int         MAX_RESULTS   = 21;
    // Kind 3 has no meaning; the engine should swallow it without a result
    localparam logic [1:0] KIND_SPARE    = 2'd3;
    // Quiet cycles after the last result before the engine counts as idle
    localparam int         SETTLE_CYCLES = 32;
    localparam longint     RUN_LIMIT_NS  = 64'd5_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the results of each accepted item and checks them
    // ------------------------------------------------------------------------
    class rx_result_board;
        result_t      results_due[$];
        result_t      burst[$];
        int           errors;
        proto_state_t ps;
        logic [8:0]   fcount;
        logic [7:0]   ftype;
        logic [7:0]   flen;
        logic [7:0]   enqlen;
        logic [7:0]   idle;
        logic [7:0]   tmo_reg;

        function new();
            errors  = 0;
            tmo_reg = 8'd120;
            ps      = PS_WAIT_START;
            idle    = 8'd0;
            clear_frame();
        endfunction

        function void clear_frame();
            fcount = 9'd0;
            ftype  = 8'd0;
            flen   = 8'd0;
            enqlen = 8'd0;
        endfunction

        function void put_result(logic [1:0] d, logic [7:0] b, logic [3:0] s);
            result_t r;
            if (burst.size() >= MAX_RESULTS)
                return;
            r.dest   = d;
            r.data   = b;
            r.last   = 1'b0;
            r.status = s;
            burst.push_back(r);
        endfunction

        function void reply(logic [7:0] a, logic [7:0] b, logic [3:0] s);
            put_result(DEST_PEER, a, STS_NONE);
            put_result(DEST_PEER, b, s);
        endfunction

        // Cancel frame: type, text length, then the text; status on the last char
        function void queue_cancel(string txt, logic [3:0] s);
            int n;
            n = txt.len();
            put_result(DEST_PEER, FT_CAN, STS_NONE);
            put_result(DEST_PEER, 8'(n), STS_NONE);
            for (int i = 0; i < n; i++)
                put_result(DEST_PEER, txt[i], (i == n - 1) ? s : STS_NONE);
        endfunction

        function void fire_timeout();
            clear_frame();
            idle = 8'd0;
            case (ps)
                PS_WAIT_START, PS_WAIT_HEADER:
                begin
                    queue_cancel("Receive timeout", STS_TIMEOUT);
                    ps = PS_CANCEL_WAIT;
                end
                PS_DATA:
                begin
                    queue_cancel("Timeout", STS_TIMEOUT);
                    ps = PS_CANCEL_WAIT;
                end
                default:
                begin
                    put_result(DEST_STATUS, 8'd0, STS_TIMEOUT);
                    ps = PS_WAIT_START;
                end
            endcase
        endfunction

        function void close_frame();
            logic [7:0] t;
            logic [7:0] l;
            t = ftype;
            l = flen;
            clear_frame();
            // A peer cancel ends the session whatever the state
            if (t == FT_CAN)
            begin
                reply(FT_ACK, RPL_CA, STS_PEER_ABORT);
                ps = PS_WAIT_START;
                return;
            end
            case (ps)
                PS_WAIT_START:
                begin
                    if (t == FT_ENQ && l == 8'h01)
                    begin
                        reply(FT_ACK, RPL_RR, STS_NONE);
                        ps = PS_WAIT_HEADER;
                    end
                    else if (t == FT_NAK)
                    begin
                        put_result(DEST_STATUS, 8'd0, STS_NOT_READY);
                    end
                end
                PS_WAIT_HEADER:
                begin
                    if (t == FT_HEADER && l != 8'd0)
                    begin
                        reply(FT_ACK, RPL_RF, STS_HEADER_DONE);
                        ps = PS_DATA;
                    end
                    else if (t == FT_ENQ && l == 8'h01)
                    begin
                        // repeated start: stay put
                    end
                    else if (t == FT_EOT && l == 8'h01)
                    begin
                        reply(FT_ACK, RPL_AT, STS_SESSION_END);
                        ps = PS_WAIT_START;
                    end
                    else
                    begin
                        queue_cancel("Protocol violation", STS_PROTO_ERR);
                        ps = PS_CANCEL_WAIT;
                    end
                end
                PS_DATA:
                begin
                    if (t == FT_DATA)
                    begin
                        // payload went out byte by byte already
                    end
                    else if (t == FT_EOF && l == 8'h01)
                    begin
                        reply(FT_ACK, RPL_AF, STS_FILE_DONE);
                        ps = PS_WAIT_HEADER;
                    end
                    else
                    begin
                        queue_cancel("Protocol violation", STS_PROTO_ERR);
                        ps = PS_CANCEL_WAIT;
                    end
                end
                default:
                begin
                    if (t == FT_ACK && l == RPL_CA)
                    begin
                        put_result(DEST_STATUS, 8'd0, STS_SESSION_END);
                        ps = PS_WAIT_START;
                    end
                    else
                    begin
                        reply(FT_ACK, RPL_CA, STS_NONE);
                    end
                end
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            int pos;
            int n;
            int want;
            bit done;
            pos  = int'(fcount);
            n    = pos + 1;
            idle = 8'd0;
            if (pos == 0)
            begin
                ftype  = b;
                flen   = 8'd0;
                enqlen = 8'd0;
            end
            else if (pos == 1)
            begin
                flen = b;
            end
            else if (pos == 2)
            begin
                enqlen = b;
            end
            // Stream payload and header text as it arrives
            if (pos >= 2)
            begin
                if (ps == PS_DATA && ftype == FT_DATA)
                    put_result(DEST_DATA, b, STS_NONE);
                else if (ps == PS_WAIT_HEADER && ftype == FT_HEADER && flen != 8'd0)
                    put_result(DEST_HEADER, b, STS_NONE);
            end
            case (ftype)
                FT_ACK, FT_EOF, FT_EOT:
                    done = (n >= 2);
                FT_DATA:
                begin
                    want = (flen == 8'd0) ? 256 : int'(flen);
                    done = (n >= 2) && (n >= want + 2);
                end
                FT_HEADER, FT_NAK, FT_CAN, FT_DLE:
                    done = (n >= 2) && (n >= int'(flen) + 2);
                FT_ENQ:
                    done = (n >= 2 && flen == 8'h01) || (n >= 3 && n >= int'(enqlen) + 3);
                default:
                    done = 1'b1;
            endcase
            if (n >= FRAME_LIMIT)
                done = 1'b1;
            fcount = 9'(n);
            if (done)
                close_frame();
        endfunction

        // Work out the results of one accepted item and queue them
        function void note_item(logic [1:0] k, logic [7:0] b);
            result_t    r;
            logic [7:0] lim;
            burst.delete();
            lim = (tmo_reg == 8'd0) ? 8'd1 : tmo_reg;
            case (k)
                KIND_BYTE:
                    take_byte(b);
                KIND_TICK:
                begin
                    if (idle != 8'hFF)
                        idle = idle + 8'd1;
                    if (idle >= lim)
                        fire_timeout();
                end
                KIND_ABORT:
                begin
                    queue_cancel("Aborted by operator", STS_OPER_ABORT);
                    ps = PS_WAIT_START;
                    clear_frame();
                    idle = 8'd0;
                end
                default:
                    ;
            endcase
            if (burst.size() > 0)
            begin
                r      = burst.pop_back();
                r.last = 1'b1;
                burst.push_back(r);
            end
            foreach (burst[i])
                results_due.push_back(burst[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_result(logic [1:0] d, logic [7:0] b, logic l, logic [3:0] s);
            result_t want;
            if (results_due.size() == 0)
            begin
                report($sformatf("unexpected result dest %0d byte %02h last %0d code %0d",
                                 d, b, l, s));
                return;
            end
            want = results_due.pop_front();
            if (d !== want.dest)
                report($sformatf("dest got %0d want %0d", d, want.dest));
            if (b !== want.data)
                report($sformatf("out_byte got %02h want %02h", b, want.data));
            if (l !== want.last)
                report($sformatf("last got %0d want %0d", l, want.last));
            if (s !== want.status)
                report($sformatf("status code got %0d want %0d", s, want.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       empty;
    logic       pop;
    logic [1:0] dest;
    logic [7:0] out_byte;
    logic       last;
    logic [3:0] status;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    rx_result_board board = new();
    bit             src_calm  = 1'b0;
    bit             sink_calm = 1'b0;
    int             items_sent = 0;

    yapp_file_receiver_engine #(
        .FRAME_CAP (FRAME_LIMIT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .dest        (dest),
        .out_byte    (out_byte),
        .last        (last),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one item and hold it until a transfer happens; push stays high
    // afterwards so back-to-back items need no gap. Callers that stop sending
    // must drop push themselves.
    task automatic send_item(input logic [1:0] k, input logic [7:0] b);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        kind    <= k;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_item(k, b);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(KIND_BYTE, b);
    endtask

    // Type, length, then a run of random body bytes
    task automatic send_frame(input logic [7:0] t, input logic [7:0] l, input int body);
        send_byte(t);
        send_byte(l);
        repeat (body)
            send_byte(rand_byte());
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(KIND_TICK, rand_byte());
    endtask

    // Drop push and hold until every predicted result has been taken, then
    // let the engine finish any item that produces nothing.
    task automatic wait_idle();
        push <= 1'b0;
        while (board.results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_timeout(input logic [7:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.tmo_reg = v;
    endtask

    task automatic peer_cancel();
        int n;
        n = $urandom_range(0, 4);
        send_frame(FT_CAN, 8'(n), n);
    endtask

    // Occasional disturbance inside an otherwise clean session
    task automatic maybe_upset();
        case ($urandom_range(0, 29))
            0: send_item(KIND_TICK, rand_byte());
            1: send_item(KIND_ABORT, rand_byte());
            2: peer_cancel();
            3: send_byte(rand_byte());
            4: send_item(KIND_SPARE, rand_byte());
            default: ;
        endcase
    endtask

    // Data block length byte: mostly short, very rarely the longest ones
    function automatic logic [7:0] pick_block_len(input bit force_long);
        int r;
        if (force_long)
            return 8'd0;
        r = $urandom_range(0, 199);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(1, 10));
    endfunction

    // Start, one or two files of header plus data blocks, end of session
    task automatic file_session(input bit force_long);
        int         files;
        int         blocks;
        int         hlen;
        logic [7:0] dlen;
        send_frame(FT_ENQ, 8'h01, 0);
        if ($urandom_range(0, 9) == 0)
            send_frame(FT_ENQ, 8'h01, 0);
        files = $urandom_range(1, 2);
        repeat (files)
        begin
            maybe_upset();
            hlen = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 12);
            send_frame(FT_HEADER, 8'(hlen), hlen);
            blocks = $urandom_range(1, 3);
            repeat (blocks)
            begin
                maybe_upset();
                dlen = pick_block_len(force_long);
                force_long = 1'b0;
                send_frame(FT_DATA, dlen, (dlen == 8'd0) ? 256 : int'(dlen));
            end
            maybe_upset();
            send_frame(FT_EOF, 8'h01, 0);
        end
        send_frame(FT_EOT, 8'h01, 0);
    endtask

    // Provoke a protocol violation, then answer the cancel in some way
    task automatic cancel_handshake();
        send_frame(FT_ENQ, 8'h01, 0);
        send_byte(8'h07);
        case ($urandom_range(0, 3))
            0: send_frame(FT_ACK, RPL_CA, 0);
            1:
            begin
                send_frame(FT_ACK, rand_byte(), 0);
                send_frame(FT_ACK, RPL_CA, 0);
            end
            2: send_ticks($urandom_range(1, 3));
            default: peer_cancel();
        endcase
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_item(2'($urandom_range(0, 3)), rand_byte());
    endtask

    task automatic odd_frame();
        logic [7:0] l;
        int         e;
        case ($urandom_range(0, 2))
            0: send_frame(FT_NAK, 8'($urandom_range(0, 3)), 0);
            1: send_frame(FT_DLE, 8'd2, 2);
            default:
            begin
                // Enquiry with a length other than one reads an extra count
                l = rand_byte();
                if (l == 8'h01)
                    l = 8'h00;
                e = $urandom_range(0, 5);
                send_byte(FT_ENQ);
                send_byte(l);
                send_byte(8'(e));
                repeat (e)
                    send_byte(rand_byte());
            end
        endcase
    endtask

    // Random mix, mostly well-formed sessions, until goal items have gone in
    task automatic run_mix(input int goal);
        int pick;
        int top;
        while (items_sent < goal)
        begin
            src_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                file_session(1'b0);
            else if (pick < 70)
                cancel_handshake();
            else if (pick < 80)
                noise_burst();
            else if (pick < 85)
                send_item(KIND_ABORT, rand_byte());
            else if (pick < 92)
            begin
                top = (board.tmo_reg > 8'd8) ? 4 : int'(board.tmo_reg) + 1;
                send_ticks($urandom_range(1, top));
            end
            else
                odd_frame();
            // Now and then hold the sender until the result queue runs dry
            if ($urandom_range(0, 19) == 0)
                wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        push        <= 1'b0;
        kind        <= KIND_BYTE;
        rx_byte     <= 8'd0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset timeout
        send_item(KIND_SPARE, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_ABORT, 8'hA5);
        send_frame(FT_ENQ, 8'h01, 0);
        send_frame(FT_HEADER, 8'd2, 2);
        send_byte(FT_DATA);
        send_byte(8'h01);
        send_byte(8'h80);
        send_frame(FT_EOF, 8'h01, 0);
        send_frame(FT_EOT, 8'h01, 0);
        send_frame(FT_NAK, 8'h00, 0);
        send_frame(FT_CAN, 8'h00, 0);

        // Shortest timeout: every tick fires
        set_timeout(8'd1);
        run_mix(items_sent + 30);

        // Longest timeout, then a session with the 256-byte data block
        set_timeout(8'd255);
        file_session(1'b1);

        // A few ticks to fire
        set_timeout(8'($urandom_range(2, 6)));
        run_mix(items_sent + 20);

        wait_idle();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, with calm stretches, then check each transfer
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            board.check_result(dest, out_byte, last, status);
            if ($urandom_range(0, 40) == 0)
                sink_calm = ~sink_calm;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
